>>> hw/rtl/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, constants and helpers of the step sequencer with lookahead.
// ----------------------------------------------------------------------------
package ssl_pkg;

	localparam int STEPS              = 16;
	localparam int TRACKS             = 4;
	localparam int MAX_STEPS_PER_TICK = 4;

	localparam int STEP_W  = 4;
	localparam int TRK_W   = 2;
	localparam int FRAME_W = 48;
	localparam int LEN_W   = 20;
	localparam int CNT_W   = $clog2(MAX_STEPS_PER_TICK + 1);

	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [LEN_W-1:0] TEMPO_RESET     = LEN_W'(6000);
	localparam logic [LEN_W-1:0] LOOKAHEAD_RESET = LEN_W'(4800);

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_START     = 3'd1;
	localparam logic [2:0] OP_STOP      = 3'd2;
	localparam logic [2:0] OP_SET_CELL  = 3'd3;
	localparam logic [2:0] OP_SET_TEMPO = 3'd4;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [FRAME_W-1:0] now_frame;
		logic [TRK_W-1:0]   track_sel;
		logic [STEP_W-1:0]  step_sel;
		logic               cell_on;
		logic [LEN_W-1:0]   step_length;
	} cmd_t;

	typedef struct packed {
		logic               hit_valid;
		logic [TRK_W-1:0]   hit_track;
		logic [STEP_W-1:0]  hit_step;
		logic [FRAME_W-1:0] target_frame;
		logic [STEP_W-1:0]  playhead;
		logic               running;
		logic               last;
	} result_t;

	// One queued record: either a due step with its pattern column, or the
	// closing status of an item.
	typedef struct packed {
		logic               last;
		logic               running;
		logic [STEP_W-1:0]  playhead;
		logic [STEP_W-1:0]  step;
		logic [FRAME_W-1:0] frame;
		logic [TRACKS-1:0]  col;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t data;
	} push_t;

	function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s);
		logic [STEP_W-1:0] r;
		if (s == STEP_W'(STEPS - 1)) begin
			r = '0;
		end else begin
			r = s + STEP_W'(1);
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/ssl_front.sv
// ----------------------------------------------------------------------------
// ssl_front
// Takes commands, keeps the sequencer state and queues one status record per
// command, after the step records that a tick schedules.
// ----------------------------------------------------------------------------
module ssl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ssl_pkg::cmd_t              cmd,
	input  logic                       cfg_we,
	input  logic [ssl_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                       q_full,
	output ssl_pkg::push_t             push
);
	import ssl_pkg::*;

	localparam logic [1:0] F_IDLE   = 2'd0;
	localparam logic [1:0] F_COUNT  = 2'd1;
	localparam logic [1:0] F_PUSH   = 2'd2;
	localparam logic [1:0] F_STATUS = 2'd3;

	logic [1:0]                    state_q;
	logic [TRACKS-1:0][STEPS-1:0]  pattern_q;
	logic [STEP_W-1:0]             step_q;
	logic [FRAME_W-1:0]            next_frame_q;
	logic                          play_q;
	logic [LEN_W-1:0]              tempo_q;
	logic [LEN_W-1:0]              lookahead_q;

	logic [FRAME_W:0]              window_end_q;
	logic [FRAME_W-1:0]            scan_frame_q;
	logic [STEP_W-1:0]             scan_step_q;
	logic [CNT_W-1:0]              count_q;
	logic [STEP_W-1:0]             playhead_fin_q;

	logic                          due;
	logic [TRACKS-1:0]             col;

	assign busy = (state_q != F_IDLE);
	assign due  = (count_q < CNT_W'(MAX_STEPS_PER_TICK)) &&
		({1'b0, scan_frame_q} < window_end_q);

	always_comb begin
		for (int t = 0; t < TRACKS; t++) begin
			col[t] = pattern_q[t][step_q];
		end
	end

	always_comb begin
		push.valid         = ((state_q == F_PUSH) || (state_q == F_STATUS)) && !q_full;
		push.data.last     = (state_q == F_STATUS);
		push.data.running  = play_q;
		push.data.playhead = (state_q == F_STATUS) ? step_q : playhead_fin_q;
		push.data.step     = step_q;
		push.data.frame    = next_frame_q;
		push.data.col      = col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			pattern_q      <= '0;
			step_q         <= '0;
			next_frame_q   <= '0;
			play_q         <= 1'b0;
			tempo_q        <= TEMPO_RESET;
			lookahead_q    <= LOOKAHEAD_RESET;
			count_q        <= '0;
			window_end_q   <= '0;
			scan_frame_q   <= '0;
			scan_step_q    <= '0;
			playhead_fin_q <= '0;
		end else begin
			if (cfg_we) begin
				lookahead_q <= cfg_wdata;
			end
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_STATUS;
						unique case (cmd.opcode)
							OP_TICK: begin
								if (play_q) begin
									window_end_q <= (FRAME_W + 1)'(cmd.now_frame) +
										(FRAME_W + 1)'(lookahead_q);
									scan_frame_q <= next_frame_q;
									scan_step_q  <= step_q;
									count_q      <= '0;
									state_q      <= F_COUNT;
								end
							end
							OP_START: begin
								if (!play_q) begin
									play_q       <= 1'b1;
									step_q       <= '0;
									next_frame_q <= cmd.now_frame;
								end
							end
							OP_STOP: begin
								play_q <= 1'b0;
							end
							OP_SET_CELL: begin
								if ((32'(cmd.track_sel) < TRACKS) &&
									(32'(cmd.step_sel) < STEPS)) begin
									pattern_q[cmd.track_sel][cmd.step_sel] <= cmd.cell_on;
								end
							end
							OP_SET_TEMPO: begin
								if (cmd.step_length != '0) begin
									tempo_q <= cmd.step_length;
								end
							end
							default: begin
							end
						endcase
					end
				end
				F_COUNT: begin
					// Count the due steps first so that every hit can carry
					// the playhead as it stands after the whole tick.
					if (due) begin
						count_q      <= count_q + CNT_W'(1);
						scan_frame_q <= scan_frame_q + FRAME_W'(tempo_q);
						scan_step_q  <= next_step(scan_step_q);
					end else begin
						playhead_fin_q <= scan_step_q;
						state_q        <= (count_q == '0) ? F_STATUS : F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						step_q       <= next_step(step_q);
						next_frame_q <= next_frame_q + FRAME_W'(tempo_q);
						count_q      <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= F_STATUS;
						end
					end
				end
				F_STATUS: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/ssl_queue.sv
// ----------------------------------------------------------------------------
// ssl_queue
// Short first-in first-out queue of records between front and back.
// ----------------------------------------------------------------------------
module ssl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  ssl_pkg::push_t push,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output ssl_pkg::qent_t rd_data
);
	import ssl_pkg::*;

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_pop;

	assign full    = (cnt_q == (QAW + 1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + (QAW + 1)'(1);
			end else if (!push.valid && do_pop) begin
				cnt_q <= cnt_q - (QAW + 1)'(1);
			end
		end
	end

endmodule

>>> hw/rtl/ssl_back.sv
// ----------------------------------------------------------------------------
// ssl_back
// Drains queued records: one hit per set track of a step, in ascending track
// order, then the status result, each from a registered output.
// ----------------------------------------------------------------------------
module ssl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  ssl_pkg::qent_t  rd_data,
	output logic            pop,
	output logic            strobe,
	output ssl_pkg::result_t result
);
	import ssl_pkg::*;

	logic               have_q;
	logic [TRACKS-1:0]  col_q;
	logic [STEP_W-1:0]  step_q;
	logic [FRAME_W-1:0] frame_q;
	logic [STEP_W-1:0]  playhead_q;
	logic               running_q;
	logic               strobe_q;
	result_t            res_q;

	logic [TRK_W-1:0]   idx;
	logic [TRACKS-1:0]  col_rest;

	assign pop    = !have_q && !empty;
	assign strobe = strobe_q;
	assign result = res_q;

	// Lowest set track of the column still to be sent.
	always_comb begin
		idx = '0;
		for (int t = TRACKS - 1; t >= 0; t--) begin
			if (col_q[t]) begin
				idx = TRK_W'(t);
			end
		end
		col_rest = col_q & ~(TRACKS'(1) << idx);
	end

	always_ff @(posedge clk) begin
		if (have_q) begin
			col_q               <= col_rest;
			res_q.hit_valid     <= 1'b1;
			res_q.hit_track     <= idx;
			res_q.hit_step      <= step_q;
			res_q.target_frame  <= frame_q;
			res_q.playhead      <= playhead_q;
			res_q.running       <= running_q;
			res_q.last          <= 1'b0;
		end else if (!empty) begin
			col_q      <= rd_data.col;
			step_q     <= rd_data.step;
			frame_q    <= rd_data.frame;
			playhead_q <= rd_data.playhead;
			running_q  <= rd_data.running;
			res_q.hit_valid    <= 1'b0;
			res_q.hit_track    <= '0;
			res_q.hit_step     <= '0;
			res_q.target_frame <= '0;
			res_q.playhead     <= rd_data.playhead;
			res_q.running      <= rd_data.running;
			res_q.last         <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (have_q) begin
				strobe_q <= |col_q;
				have_q   <= |col_rest;
			end else if (!empty) begin
				// A status record goes straight out; a step record is held
				// while its tracks are sent.
				strobe_q <= rd_data.last;
				have_q   <= !rd_data.last;
			end
		end
	end

endmodule

>>> hw/rtl/step_sequencer_lookahead.sv
// ----------------------------------------------------------------------------
// step_sequencer_lookahead
// Sixteen-step pattern sequencer that schedules hits ahead of sample time.
//
//   transfer  | ports                    | rule
//   ----------+--------------------------+------------------------------------
//   command   | start, busy, cmd         | taken at an edge with start & !busy
//   result    | strobe, result           | one cycle each, cannot be held off
//   register  | cfg_we, cfg_wdata        | written at an edge with cfg_we
//
// The front is busy for every command. For a tick it first counts the due
// steps, then queues them, then queues one status record, and it waits while
// the queue is full. The back sends one hit per cycle while it holds a step
// record, and loads each queued record before it sends that record's hits.
// An eight-entry queue lets the front take the next command while the back
// is still draining. Reset clears the pattern and the play state.
// ----------------------------------------------------------------------------
module step_sequencer_lookahead (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  ssl_pkg::cmd_t             cmd,
	input  logic                      cfg_we,
	input  logic [ssl_pkg::LEN_W-1:0] cfg_wdata,
	output logic                      strobe,
	output ssl_pkg::result_t          result
);
	import ssl_pkg::*;

	push_t push;
	qent_t rd_data;
	logic  q_full;
	logic  q_empty;
	logic  pop;

	ssl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push)
	);

	ssl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.rd_data (rd_data)
	);

	ssl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.rd_data (rd_data),
		.pop     (pop),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

>>> hw/rtl/ssl_checker.sv
// ----------------------------------------------------------------------------
// ssl_checker
// Port-level checks of the step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ssl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             strobe,
	input ssl_pkg::result_t result
);
	import ssl_pkg::*;

	// Every accepted command makes the front busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after a command transfer");

	a_hit_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.hit_valid |-> !result.last)
		else $error("hit result marked as last");

	a_hit_running: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.hit_valid |-> result.running)
		else $error("hit result while not running");

	// Results of one command strobed in consecutive cycles report the same playhead.
	a_same_playhead: assert property (@(posedge clk) disable iff (!arst_n)
		$past(strobe) && !$past(result.last) && strobe |->
			result.playhead == $past(result.playhead))
		else $error("playhead changed within one command");

endmodule

bind step_sequencer_lookahead ssl_checker u_ssl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lookahead step sequencer. Commands go in
// through the start/busy transfer. A model inside the bench predicts the hits
// and the status that each accepted command should produce. A checker
// compares every strobed result, field by field, against the oldest pending
// prediction. Directed cases come first, then three random phases that run
// under different lookahead settings and different amounts of sender idling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ssl_pkg::*;

	// Opcodes that the block does not define.
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	localparam logic [FRAME_W-1:0] FRAME_MAX  = '1;
	localparam logic [LEN_W-1:0]   LEN_MAX    = '1;
	localparam int                 SETTLE_CYC = 24;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	cmd_t             cmd       = '0;
	logic             cfg_we    = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	logic             strobe;
	result_t          result;

	step_sequencer_lookahead dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.result    (result)
	);

	// Sequencer state as the bench expects it to be.
	logic [STEPS-1:0]   pat_bits [TRACKS];
	logic [STEP_W-1:0]  play_step  = '0;
	logic [FRAME_W-1:0] play_frame = '0;
	logic               playing    = 1'b0;
	logic [LEN_W-1:0]   frame_len  = TEMPO_RESET;
	logic [LEN_W-1:0]   window_len = LOOKAHEAD_RESET;

	result_t            due_results [$];
	int                 errors     = 0;
	logic [FRAME_W-1:0] song_pos   = '0;
	int                 quiet_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// The slowest correct run is well under 100 us; this allows ten times that.
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		for (int t = 0; t < TRACKS; t++) begin
			pat_bits[t] = '0;
		end
	end

	task automatic log_mismatch(input string msg);
		$display("%0t ns  MISMATCH  %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [FRAME_W-1:0] got,
			input logic [FRAME_W-1:0] want);
		if (got !== want) begin
			log_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
		end
	endtask

	// Works out the results of one accepted command and queues them.
	function automatic void advance_sequencer(input cmd_t c);
		result_t     batch [$];
		result_t     r;
		logic [48:0] window_end;
		int          handled;

		case (c.opcode)
			OP_TICK: begin
				if (playing) begin
					window_end = {1'b0, c.now_frame} + 49'(window_len);
					handled = 0;
					while (handled < MAX_STEPS_PER_TICK && {1'b0, play_frame} < window_end) begin
						for (int t = 0; t < TRACKS; t++) begin
							if (pat_bits[t][play_step]) begin
								r = '0;
								r.hit_valid    = 1'b1;
								r.hit_track    = TRK_W'(t);
								r.hit_step     = play_step;
								r.target_frame = play_frame;
								batch = {batch, r};
							end
						end
						play_step  = (int'(play_step) == STEPS - 1) ? '0 : play_step + STEP_W'(1);
						play_frame = play_frame + FRAME_W'(frame_len);
						handled++;
					end
				end
			end
			OP_START: begin
				if (!playing) begin
					playing    = 1'b1;
					play_step  = '0;
					play_frame = c.now_frame;
				end
			end
			OP_STOP: begin
				playing = 1'b0;
			end
			OP_SET_CELL: begin
				if (int'(c.track_sel) < TRACKS && int'(c.step_sel) < STEPS) begin
					pat_bits[c.track_sel][c.step_sel] = c.cell_on;
				end
			end
			OP_SET_TEMPO: begin
				if (c.step_length != '0) begin
					frame_len = c.step_length;
				end
			end
			default: begin
			end
		endcase

		r = '0;
		r.last = 1'b1;
		batch = {batch, r};
		foreach (batch[i]) begin
			r = batch[i];
			r.playhead = play_step;
			r.running  = playing;
			due_results = {due_results, r};
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				log_mismatch($sformatf("result %h with nothing pending", result));
			end else begin
				want = due_results.pop_front();
				check_field("hit_valid", FRAME_W'(result.hit_valid), FRAME_W'(want.hit_valid));
				check_field("hit_track", FRAME_W'(result.hit_track), FRAME_W'(want.hit_track));
				check_field("hit_step", FRAME_W'(result.hit_step), FRAME_W'(want.hit_step));
				check_field("target_frame", result.target_frame, want.target_frame);
				check_field("playhead", FRAME_W'(result.playhead), FRAME_W'(want.playhead));
				check_field("running", FRAME_W'(result.running), FRAME_W'(want.running));
				check_field("last", FRAME_W'(result.last), FRAME_W'(want.last));
			end
		end
	end

	// Holds start high until the command is taken; start stays high on return
	// so that back-to-back commands follow without start going low between them.
	task automatic send_cmd(input cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		advance_sequencer(c);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_lookahead(input logic [LEN_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_len  = v;
	endtask

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic [FRAME_W-1:0] now,
			input int trk, input int stp, input logic on, input logic [LEN_W-1:0] len);
		cmd_t c;
		c.opcode      = op;
		c.now_frame   = now;
		c.track_sel   = TRK_W'(trk);
		c.step_sel    = STEP_W'(stp);
		c.cell_on     = on;
		c.step_length = len;
		return c;
	endfunction

	function automatic logic [FRAME_W-1:0] rand_frame();
		return FRAME_W'({$urandom(), $urandom()});
	endfunction

	// Mostly a playable stream: ticks that move forward in time, pattern edits,
	// start/stop and tempo changes, with some noise mixed in.
	function automatic cmd_t random_cmd();
		cmd_t        c;
		int          pick;
		int          k;
		int unsigned adv;

		c.now_frame   = rand_frame();
		c.track_sel   = TRK_W'($urandom());
		c.step_sel    = STEP_W'($urandom());
		c.cell_on     = 1'($urandom());
		c.step_length = LEN_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			c.opcode = OP_TICK;
			if ($urandom_range(0, 9) != 0) begin
				k = $urandom_range(0, 9);
				if (k < 6) begin
					adv = $urandom_range(0, 32'(frame_len));
				end else if (k < 9) begin
					adv = $urandom_range(0, 32'(frame_len) * 6);
				end else begin
					adv = 0;
				end
				song_pos    = song_pos + FRAME_W'(adv);
				c.now_frame = song_pos;
			end
		end else if (pick < 75) begin
			c.opcode  = OP_SET_CELL;
			c.cell_on = ($urandom_range(0, 99) < 65);
		end else if (pick < 83) begin
			c.opcode = OP_START;
			if ($urandom_range(0, 7) == 0) begin
				song_pos = FRAME_MAX - FRAME_W'($urandom_range(0, 20000));
			end
			c.now_frame = song_pos;
		end else if (pick < 89) begin
			c.opcode = OP_STOP;
		end else if (pick < 95) begin
			c.opcode = OP_SET_TEMPO;
			k = $urandom_range(0, 9);
			if (k == 0) begin
				c.step_length = '0;
			end else if (k != 1) begin
				c.step_length = LEN_W'($urandom_range(1, 3000));
			end
		end else begin
			c.opcode = 3'($urandom_range(int'(OP_RSVD5), int'(OP_RSVD7)));
		end
		return c;
	endfunction

	// Sender idling, with the occasional run of commands without any gap.
	task automatic pace(input int idle_pct);
		if (quiet_left > 0) begin
			quiet_left--;
		end else if ($urandom_range(0, 99) < 4) begin
			quiet_left = $urandom_range(10, 30);
		end else if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic test_stopped_and_unknown();
		send_cmd(make_cmd(OP_TICK, FRAME_MAX, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_RSVD7, FRAME_MAX, 3, 15, 1'b1, LEN_MAX));
		send_cmd(make_cmd(OP_RSVD6, FRAME_MAX, 2, 7, 1'b1, LEN_MAX));
		send_cmd(make_cmd(OP_RSVD5, '0, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_SET_TEMPO, '0, 0, 0, 1'b0, '0));
	endtask

	task automatic test_pattern_and_play();
		send_cmd(make_cmd(OP_SET_CELL, '0, 0, 0, 1'b1, '0));
		send_cmd(make_cmd(OP_SET_CELL, '0, 1, 0, 1'b1, '0));
		send_cmd(make_cmd(OP_SET_CELL, '0, 2, 1, 1'b1, '0));
		send_cmd(make_cmd(OP_SET_CELL, '0, 3, 15, 1'b1, '0));
		send_cmd(make_cmd(OP_SET_CELL, '0, 3, 3, 1'b1, '0));
		send_cmd(make_cmd(OP_SET_CELL, '0, 3, 3, 1'b0, '0));
		send_cmd(make_cmd(OP_START, 48'd1000, 0, 0, 1'b0, '0));
		// Already playing, so this start must leave the position alone.
		send_cmd(make_cmd(OP_START, 48'd5, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_TICK, 48'd1000, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_TICK, 48'd100000, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_SET_TEMPO, '0, 0, 0, 1'b0, LEN_MAX));
		send_cmd(make_cmd(OP_TICK, 48'd200000, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_STOP, '0, 0, 0, 1'b0, '0));
	endtask

	// Start just below the top of the frame range so that the scheduled
	// frames wrap while the window end does not.
	task automatic test_frame_wrap();
		send_cmd(make_cmd(OP_SET_TEMPO, '0, 0, 0, 1'b0, 20'd1));
		send_cmd(make_cmd(OP_START, FRAME_MAX - FRAME_W'(1), 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_TICK, FRAME_MAX, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_TICK, FRAME_MAX, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_STOP, '0, 0, 0, 1'b0, '0));
	endtask

	task automatic test_lookahead_extremes();
		write_lookahead('0);
		send_cmd(make_cmd(OP_START, '0, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_TICK, '0, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_TICK, 48'd1, 0, 0, 1'b0, '0));
		write_lookahead(LEN_MAX);
		send_cmd(make_cmd(OP_TICK, '0, 0, 0, 1'b0, '0));
		send_cmd(make_cmd(OP_STOP, '0, 0, 0, 1'b0, '0));
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct,
			input logic [LEN_W-1:0] window);
		write_lookahead(window);
		song_pos = play_frame;
		for (int i = 0; i < count; i++) begin
			pace(idle_pct);
			send_cmd(random_cmd());
			// Now and then let everything drain before the next command.
			if ($urandom_range(0, 99) < 2) begin
				drain_results();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stopped_and_unknown();
		test_pattern_and_play();
		test_frame_wrap();
		test_lookahead_extremes();
		test_random_traffic(160, 32, LEN_W'($urandom_range(1, 20000)));
		test_random_traffic(160, 61, '0);
		test_random_traffic(150, 0, LEN_MAX);

		drain_results();
		if (due_results.size() != 0) begin
			log_mismatch($sformatf("%0d results never arrived", due_results.size()));
		end
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
